@@ design/scrd_pkg.sv @@
// ----------------------------------------------------------------------------
// scrd_pkg
// Shared types and constants for the sustained clip run detector.
// ----------------------------------------------------------------------------
package scrd_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned SMP_W    = 32;
  localparam int unsigned THR_W    = 31;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned POS_W    = 48;
  localparam int unsigned CFG_W    = 32;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [0:0] {
    CFG_CLIP_THRESHOLD = 1'b0,
    CFG_MIN_RUN        = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                    action;
    logic [CHAN_W-1:0]       channel;
    logic signed [SMP_W-1:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic              event_valid;
    logic [CHAN_W-1:0] event_channel;
    logic [POS_W-1:0]  event_start;
    logic [LEN_W-1:0]  event_length;
    logic [LEN_W-1:0]  total_events;
    logic [POS_W-1:0]  clip_total;
  } out_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] run_length;
    logic [POS_W-1:0] run_start;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] event_count;
    logic [POS_W-1:0] clipped_count;
  } chan_state_t;

  typedef struct packed {
    logic [THR_W-1:0] clip_threshold;
    logic [LEN_W-1:0] min_run;
  } cfg_t;

endpackage

@@ design/scrd_if.sv @@
// ----------------------------------------------------------------------------
// scrd_in_if / scrd_out_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface scrd_in_if;
  logic               valid;
  logic               ready;
  scrd_pkg::in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface scrd_out_if;
  logic                valid;
  logic                ready;
  scrd_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ design/scrd_update.sv @@
// ----------------------------------------------------------------------------
// scrd_update
// Next channel state and result word for one input word.
// ----------------------------------------------------------------------------
module scrd_update (
  input  scrd_pkg::in_word_t    in_word_i,
  input  scrd_pkg::chan_state_t cur_i,
  input  scrd_pkg::cfg_t        cfg_i,
  output scrd_pkg::chan_state_t nxt_o,
  output scrd_pkg::out_word_t   res_o
);
  import scrd_pkg::*;

  logic [SMP_W:0]   mag;
  logic             clipped;
  logic             run_open;
  logic             end_run;
  logic             report;
  logic [POS_W:0]   clip_sum;
  logic [POS_W-1:0] clip_sat;
  logic [LEN_W-1:0] evt_sat;
  logic [LEN_W-1:0] len_inc;
  logic [POS_W-1:0] pos_inc;

  always_comb begin
    // exact magnitude, -2^31 gives 2^31
    mag = in_word_i.sample_value[SMP_W-1]
        ? ((SMP_W+1)'(0) - {1'b1, in_word_i.sample_value})
        : {1'b0, in_word_i.sample_value};
    clipped  = mag >= {2'b00, cfg_i.clip_threshold};
    run_open = cur_i.run_length != '0;
    end_run  = run_open && (in_word_i.action || !clipped);
    report   = end_run && (cur_i.run_length >= cfg_i.min_run);

    clip_sum = {1'b0, cur_i.clipped_count} + {(POS_W+1-LEN_W)'(0), cur_i.run_length};
    clip_sat = clip_sum[POS_W] ? POS_MAX : clip_sum[POS_W-1:0];
    evt_sat  = (cur_i.event_count == LEN_MAX) ? LEN_MAX : cur_i.event_count + 1'b1;
    len_inc  = (cur_i.run_length == LEN_MAX) ? LEN_MAX : cur_i.run_length + 1'b1;
    pos_inc  = (cur_i.position == POS_MAX) ? POS_MAX : cur_i.position + 1'b1;

    nxt_o = cur_i;
    if (end_run) begin
      nxt_o.run_length    = '0;
      nxt_o.clipped_count = clip_sat;
      if (report) begin
        nxt_o.event_count = evt_sat;
      end
    end else if (!in_word_i.action && clipped) begin
      if (!run_open) begin
        nxt_o.run_start = cur_i.position;
      end
      nxt_o.run_length = len_inc;
    end
    if (!in_word_i.action) begin
      nxt_o.position = pos_inc;
    end

    res_o.event_valid   = report;
    res_o.event_channel = in_word_i.channel;
    res_o.event_start   = report ? cur_i.run_start : '0;
    res_o.event_length  = report ? cur_i.run_length : '0;
    res_o.total_events  = nxt_o.event_count;
    res_o.clip_total    = nxt_o.clipped_count;
  end

endmodule

@@ design/sustained_clip_run_detector.sv @@
// ----------------------------------------------------------------------------
// sustained_clip_run_detector
// Per-channel detector of runs of clipped audio samples.
// ----------------------------------------------------------------------------
// Usage:
//  - in_port carries one word per sample or flush, tagged with a channel.
//    Every accepted word yields exactly one result word on out_port.
//  - A sample whose magnitude reaches clip_threshold extends the channel's
//    run; a quiet sample or a flush ends it. Ended runs of at least min_run
//    samples come out with event_valid set, plus start and length.
//  - The result is registered: it is loaded into the output register at
//    the accepting edge and can be taken in the cycle after. Throughput: one
//    word per cycle while the receiver does not stall, as each accepted word
//    does a read-modify-write of the selected channel's state flops, so words
//    for the same channel may follow back to back.
//  - Stall: in_port.ready is high whenever the output register is empty or
//    being drained this cycle; a stalled receiver holds the result and
//    back-pressures the input after one word.
//  - Reset (rst_ni low, async): all channel state clears to zero, the
//    output register empties, clip_threshold returns to full scale and
//    min_run to 1. No clearing pass is needed.
//  - Config: cfg_we_i writes cfg_data_i to register cfg_idx_i; write only
//    while idle.
// ----------------------------------------------------------------------------
module sustained_clip_run_detector (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  scrd_in_if.sink                   in_port,
  scrd_out_if.source                out_port,
  input  logic                      cfg_we_i,
  input  scrd_pkg::cfg_idx_e        cfg_idx_i,
  input  logic [scrd_pkg::CFG_W-1:0] cfg_data_i
);
  import scrd_pkg::*;

  // configuration registers
  cfg_t        cfg_q;

  // per-channel state, one flop row per channel
  chan_state_t state_q [CHANNELS];

  // output register
  logic        out_valid_q;
  out_word_t   out_word_q;

  logic        in_ready;
  logic        accept;
  logic        chan_ok;
  chan_state_t cur_state;
  chan_state_t nxt_state;
  out_word_t   upd_res;
  out_word_t   out_word_d;

  // output register empty or leaving this cycle
  assign in_ready = !out_valid_q || out_port.ready;
  assign accept   = in_port.valid && in_ready;
  assign chan_ok  = 32'(in_port.payload.channel) < CHANNELS;

  assign in_port.ready    = in_ready;
  assign out_port.valid   = out_valid_q;
  assign out_port.payload = out_word_q;

  assign cur_state = state_q[in_port.payload.channel];

  scrd_update u_update (
    .in_word_i (in_port.payload),
    .cur_i     (cur_state),
    .cfg_i     (cfg_q),
    .nxt_o     (nxt_state),
    .res_o     (upd_res)
  );

  // channels beyond the configured count are passed by untouched
  always_comb begin
    out_word_d = upd_res;
    if (!chan_ok) begin
      out_word_d               = '0;
      out_word_d.event_channel = in_port.payload.channel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_threshold <= '1;
      cfg_q.min_run        <= LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLIP_THRESHOLD: cfg_q.clip_threshold <= cfg_data_i[THR_W-1:0];
        CFG_MIN_RUN:        cfg_q.min_run        <= cfg_data_i[LEN_W-1:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state_q[i] <= '0;
      end
    end else if (accept && chan_ok) begin
      state_q[in_port.payload.channel] <= nxt_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready) begin
      out_valid_q <= accept;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

@@ design/scrd_checker.sv @@
// ----------------------------------------------------------------------------
// scrd_checker
// Port-level checks for the sustained clip run detector.
// ----------------------------------------------------------------------------
module scrd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input scrd_pkg::out_word_t out_word_i
);
  import scrd_pkg::*;

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("result dropped or changed while stalled");

  // an accepted word always shows up the next cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted word produced no result");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // no event means zero start and length
  a_no_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_word_i.event_valid |->
      out_word_i.event_start == '0 && out_word_i.event_length == '0)
    else $error("event fields nonzero without event");

  // a reported run is never empty
  a_event_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.event_valid |-> out_word_i.event_length != '0)
    else $error("event with zero length");

endmodule

bind sustained_clip_run_detector scrd_checker u_scrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_port.valid),
  .in_ready_i  (in_port.ready),
  .out_valid_i (out_port.valid),
  .out_ready_i (out_port.ready),
  .out_word_i  (out_port.payload)
);
